// ===== sv/assert_macros.svh =====
// concurrent assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/u16550_pkg.sv =====
package u16550_pkg;

   localparam int RX_RING_SLOTS_DEFAULT = 16;

   // item actions
   localparam logic [1:0] ACT_READ      = 2'd0;
   localparam logic [1:0] ACT_WRITE     = 2'd1;
   localparam logic [1:0] ACT_INJECT    = 2'd2;
   localparam logic [1:0] ACT_DEV_RESET = 2'd3;

   // register offsets
   localparam logic [2:0] OFF_RBR_THR = 3'd0;
   localparam logic [2:0] OFF_IER     = 3'd1;
   localparam logic [2:0] OFF_IIR_FCR = 3'd2;
   localparam logic [2:0] OFF_LCR     = 3'd3;
   localparam logic [2:0] OFF_MCR     = 3'd4;
   localparam logic [2:0] OFF_LSR     = 3'd5;
   localparam logic [2:0] OFF_MSR     = 3'd6;
   localparam logic [2:0] OFF_SCR     = 3'd7;

   localparam int         LCR_DLAB_BIT = 7;
   localparam int         FCR_RX_RESET_BIT = 1;
   localparam logic [7:0] LSR_TX_READY = 8'h60;
   localparam logic [7:0] LSR_OVERRUN  = 8'h02;
   localparam logic [7:0] LSR_DATA_RDY = 8'h01;
   localparam logic [7:0] IIR_NONE     = 8'h01;
   localparam logic [7:0] MSR_VALUE    = 8'h00;

endpackage

// ===== sv/uart_16550_register_model.sv =====
// channel   ports                                   direction
// req       req_valid/req_ready, action, offset,    in
//           write_data, inject_last
// rsp       rsp_valid/rsp_ready, read_data,         out
//           tx_valid, tx_byte
// one transfer in and one result out per item, one item per cycle sustained while rsp is not stalled
// an item passes through the input register, then the result register
// the receive ring is a register-file memory read through a registered port
// reset (synchronous, active high) clears pointers, registers and flags;
//   ring contents are kept and need no clearing pass
// a stall on rsp holds the result and backs up into the input register
`include "assert_macros.svh"

module uart_16550_register_model #(
   parameter int RX_RING_SLOTS = u16550_pkg::RX_RING_SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [2:0] req_reg_offset,
   input  logic [7:0] req_write_data,
   input  logic       req_inject_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte
);
   import u16550_pkg::*;

   localparam int PTR_W = $clog2(RX_RING_SLOTS);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_RING_SLOTS - 1);

   // input register
   logic       in_valid_ff;
   logic [1:0] in_action_ff;
   logic [2:0] in_offset_ff;
   logic [7:0] in_data_ff;

   // device state
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [7:0]       ier_ff, ier_in;
   logic [7:0]       lcr_ff, lcr_in;
   logic [7:0]       mcr_ff, mcr_in;
   logic [7:0]       scr_ff, scr_in;
   logic             data_ready_ff, data_ready_in;
   logic             overrun_ff, overrun_in;

   // receive ring
   logic [7:0] rx_mem [RX_RING_SLOTS];
   logic [7:0] mem_rd_ff;
   logic       mem_we;

   // result register
   logic       rsp_valid_ff;
   logic       sel_mem_ff, sel_mem_in;
   logic [7:0] read_ff, read_in;
   logic       tx_valid_ff, tx_valid_in;
   logic [7:0] tx_byte_ff, tx_byte_in;

   logic             out_free;
   logic             proc;
   logic             dlab;
   logic             ring_empty;
   logic [PTR_W-1:0] rd_next;
   logic [PTR_W-1:0] wr_next;

   // result slot free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign proc      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign dlab       = lcr_ff[LCR_DLAB_BIT];
   assign ring_empty = (rd_ptr_ff == wr_ptr_ff);
   assign rd_next    = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign wr_next    = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);

   // one pass of the register model for the item in the input register
   always_comb begin
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      ier_in        = ier_ff;
      lcr_in        = lcr_ff;
      mcr_in        = mcr_ff;
      scr_in        = scr_ff;
      data_ready_in = data_ready_ff;
      overrun_in    = overrun_ff;
      mem_we        = 1'b0;
      sel_mem_in    = 1'b0;
      read_in       = '0;
      tx_valid_in   = 1'b0;
      tx_byte_in    = '0;
      if (proc) begin
         unique case (in_action_ff)
            ACT_READ: begin
               unique case (in_offset_ff)
                  OFF_RBR_THR: begin
                     // pop; empty ring reads zero and leaves state alone
                     if (!ring_empty) begin
                        sel_mem_in = 1'b1;
                        rd_ptr_in  = rd_next;
                        if (rd_next == wr_ptr_ff) begin
                           data_ready_in = 1'b0;
                        end
                     end
                  end
                  OFF_IER:     read_in = ier_ff;
                  OFF_IIR_FCR: read_in = IIR_NONE;
                  OFF_LCR:     read_in = lcr_ff;
                  OFF_MCR:     read_in = mcr_ff;
                  OFF_LSR: begin
                     read_in = LSR_TX_READY
                             | (overrun_ff ? LSR_OVERRUN : 8'h00)
                             | (data_ready_ff ? LSR_DATA_RDY : 8'h00);
                  end
                  OFF_MSR:     read_in = MSR_VALUE;
                  OFF_SCR:     read_in = scr_ff;
               endcase
            end
            ACT_WRITE: begin
               unique case (in_offset_ff)
                  OFF_RBR_THR: begin
                     // divisor latch writes with dlab set are dropped
                     if (!dlab) begin
                        tx_valid_in = 1'b1;
                        tx_byte_in  = in_data_ff;
                     end
                  end
                  OFF_IER: begin
                     if (!dlab) begin
                        ier_in = in_data_ff;
                     end
                  end
                  OFF_IIR_FCR: begin
                     // receive fifo reset empties the ring
                     if (in_data_ff[FCR_RX_RESET_BIT]) begin
                        rd_ptr_in     = '0;
                        wr_ptr_in     = '0;
                        data_ready_in = 1'b0;
                     end
                  end
                  OFF_LCR: lcr_in = in_data_ff;
                  OFF_MCR: mcr_in = in_data_ff;
                  OFF_SCR: scr_in = in_data_ff;
                  default: begin
                     // lsr and msr are read only
                  end
               endcase
            end
            ACT_INJECT: begin
               // ring keeps one slot open; a byte into a full ring is lost
               if (wr_next != rd_ptr_ff) begin
                  mem_we        = 1'b1;
                  wr_ptr_in     = wr_next;
                  data_ready_in = 1'b1;
               end else begin
                  overrun_in = 1'b1;
               end
            end
            ACT_DEV_RESET: begin
               rd_ptr_in     = '0;
               wr_ptr_in     = '0;
               ier_in        = '0;
               lcr_in        = '0;
               mcr_in        = '0;
               scr_in        = '0;
               data_ready_in = 1'b0;
               overrun_in    = 1'b0;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         ier_ff        <= '0;
         lcr_ff        <= '0;
         mcr_ff        <= '0;
         scr_ff        <= '0;
         data_ready_ff <= 1'b0;
         overrun_ff    <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         ier_ff        <= ier_in;
         lcr_ff        <= lcr_in;
         mcr_ff        <= mcr_in;
         scr_ff        <= scr_in;
         data_ready_ff <= data_ready_in;
         overrun_ff    <= overrun_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_action_ff <= req_action;
         in_offset_ff <= req_reg_offset;
         in_data_ff   <= req_write_data;
      end
      if (proc) begin
         sel_mem_ff  <= sel_mem_in;
         read_ff     <= read_in;
         tx_valid_ff <= tx_valid_in;
         tx_byte_ff  <= tx_byte_in;
      end
   end

   // ring memory: one write port, one registered read port at the head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         rx_mem[wr_ptr_ff] <= in_data_ff;
      end
      if (proc) begin
         mem_rd_ff <= rx_mem[rd_ptr_ff];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = sel_mem_ff ? mem_rd_ff : read_ff;
   assign rsp_tx_valid  = tx_valid_ff;
   assign rsp_tx_byte   = tx_byte_ff;

   `ASSERT_IMPLIES(a_ready_tracks_ring, clock, reset, 1'b1, data_ready_ff == !ring_empty, "data ready disagrees with ring pointers")
   `ASSERT_NEXT(a_item_reaches_output, clock, reset, proc, rsp_valid_ff, "processed item did not reach the result register")
   `ASSERT_IMPLIES(a_tx_no_read, clock, reset, rsp_valid_ff && tx_valid_ff, rsp_read_data == 8'h00, "transmit result carries read data")
   `ASSERT_IMPLIES(a_overrun_sticky, clock, reset, $fell(overrun_ff), $past(reset) || ($past(proc) && $past(in_action_ff) == ACT_DEV_RESET), "overrun flag cleared without device reset")

endmodule
